// File: rtl/external_interrupt_edge_controller_unit_assert.svh
// ----------------------------------------------------------------------------
// external interrupt edge controller - assertion macros
// concurrent checks clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef EXTERNAL_INTERRUPT_EDGE_CONTROLLER_UNIT_ASSERT_SVH
`define EXTERNAL_INTERRUPT_EDGE_CONTROLLER_UNIT_ASSERT_SVH

// same-cycle implication
`define EIEC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("eiec assertion failed");

// next-cycle implication
`define EIEC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("eiec assertion failed");

`endif

// File: rtl/eiec_pkg.sv
// ----------------------------------------------------------------------------
// eiec_pkg
// widths, codes and defaults of the external interrupt edge controller
// ----------------------------------------------------------------------------
`default_nettype none

package eiec_pkg;

  localparam int unsigned LINE_W        = 16;  // lines carried by every field
  localparam int unsigned PORT_W        = 16;  // pins per gpio port
  localparam int unsigned CARRIED_PORTS = 4;   // ports carried by pin_levels
  localparam int unsigned SEL_W         = 4;   // port select bits per line
  localparam int unsigned PORT_IDX_W    = 2;   // index into the carried ports
  localparam int unsigned PINS_W        = CARRIED_PORTS * PORT_W;
  localparam int unsigned SELS_W        = LINE_W * SEL_W;

  localparam int unsigned NUM_LINES_DEF = 16;
  localparam int unsigned NUM_PORTS_DEF = 4;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned REGSEL_W = 2;
  localparam int unsigned IN_TUSER_W  = KIND_W + REGSEL_W;
  localparam int unsigned IN_TDATA_W  = 80;  // wdata, pin_levels
  localparam int unsigned OUT_TDATA_W = 40;  // rdata, irq_lines, irq_any, pad

  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 64;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // bus registers
  localparam logic [REGSEL_W-1:0] REG_MASK = 2'd0;
  localparam logic [REGSEL_W-1:0] REG_SWT  = 2'd1;
  localparam logic [REGSEL_W-1:0] REG_PEND = 2'd2;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_PORT_SEL = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_RISE_EN  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_FALL_EN  = 2'd2;

endpackage

`default_nettype wire

// File: rtl/external_interrupt_edge_controller_unit.sv
// ----------------------------------------------------------------------------
// external_interrupt_edge_controller_unit
// 16-line external interrupt controller: edge detect, mask, sw trigger
// ----------------------------------------------------------------------------
// channel   dir  handshake            payload
// in_       in   in_tvalid/in_tready  tuser kind, reg_sel; tdata wdata, pin_levels
// out_      out  out_tvalid/out_tready tdata rdata, irq_lines, irq_any
// cfg_      in   cfg_we               cfg_addr index, cfg_wdata value
//
// one transaction per cycle unless an out_tready stall holds the result register
// an input register feeds one pass of logic that updates state and loads
// the result register, which doubles as the skid stage for out_tready stalls
// rst_n is synchronous; it clears state, configuration and both valid flags
// ----------------------------------------------------------------------------
`default_nettype none

module external_interrupt_edge_controller_unit #(
  parameter int unsigned NUM_LINES = eiec_pkg::NUM_LINES_DEF,
  parameter int unsigned NUM_PORTS = eiec_pkg::NUM_PORTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output      logic                             in_tready,
  input  wire logic [eiec_pkg::IN_TDATA_W-1:0]  in_tdata,   // wdata, pin_levels
  input  wire logic [eiec_pkg::IN_TUSER_W-1:0]  in_tuser,   // kind, reg_sel
  output      logic                             out_tvalid,
  input  wire logic                             out_tready,
  output      logic [eiec_pkg::OUT_TDATA_W-1:0] out_tdata,  // rdata, irq_lines, irq_any
  input  wire logic                             cfg_we,
  input  wire logic [eiec_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [eiec_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int unsigned LW = eiec_pkg::LINE_W;
  localparam logic [LW-1:0] LINE_MASK = LW'((17'(1) << NUM_LINES) - 17'(1));
  localparam logic [eiec_pkg::SEL_W:0] PORT_LIMIT = (eiec_pkg::SEL_W + 1)'(NUM_PORTS);

  // configuration
  logic [eiec_pkg::SELS_W-1:0] sel_r;
  logic [LW-1:0]               rise_en_r;
  logic [LW-1:0]               fall_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r     <= '0;
      rise_en_r <= '0;
      fall_en_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        eiec_pkg::CFG_PORT_SEL: sel_r     <= cfg_wdata;
        eiec_pkg::CFG_RISE_EN:  rise_en_r <= cfg_wdata[LW-1:0];
        eiec_pkg::CFG_FALL_EN:  fall_en_r <= cfg_wdata[LW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                              s1_valid_r;
  logic [eiec_pkg::KIND_W-1:0]       s1_kind_r;
  logic [eiec_pkg::REGSEL_W-1:0]     s1_reg_r;
  logic [LW-1:0]                     s1_wdata_r;
  logic [eiec_pkg::PINS_W-1:0]       s1_pins_r;
  logic                              out_free;
  logic                              s1_fire;
  logic                              in_fire;

  assign out_free  = !out_tvalid || out_tready;
  assign s1_fire   = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_fire   = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_kind_r  <= in_tuser[eiec_pkg::KIND_W-1:0];
      s1_reg_r   <= in_tuser[eiec_pkg::IN_TUSER_W-1:eiec_pkg::KIND_W];
      s1_wdata_r <= in_tdata[LW-1:0];
      s1_pins_r  <= in_tdata[LW +: eiec_pkg::PINS_W];
    end
  end

  // controller state
  logic [LW-1:0] prev_r, prev_nxt;
  logic [LW-1:0] mask_r, mask_nxt;
  logic [LW-1:0] pend_r, pend_nxt;
  logic [LW-1:0] soft_r, soft_nxt;

  logic [eiec_pkg::CARRIED_PORTS-1:0][eiec_pkg::PORT_W-1:0] pins;
  logic [LW-1:0]               levels;
  logic [LW-1:0]               wdata_m;
  logic [LW-1:0]               rdata;
  logic [LW-1:0]               irq;
  logic [eiec_pkg::SEL_W-1:0]  line_sel [LW];

  assign pins    = s1_pins_r;
  assign wdata_m = s1_wdata_r & LINE_MASK;

  // per-line port mux; selects past the port count read low
  always_comb begin
    for (int l = 0; l < LW; l++) begin
      line_sel[l] = sel_r[l*eiec_pkg::SEL_W +: eiec_pkg::SEL_W];
      levels[l] = ({1'b0, line_sel[l]} < PORT_LIMIT)
               && (line_sel[l][eiec_pkg::SEL_W-1:eiec_pkg::PORT_IDX_W] == '0)
               && pins[line_sel[l][eiec_pkg::PORT_IDX_W-1:0]][l];
    end
    levels = levels & LINE_MASK;
  end

  always_comb begin
    prev_nxt = prev_r;
    mask_nxt = mask_r;
    pend_nxt = pend_r;
    soft_nxt = soft_r;
    rdata    = '0;
    unique case (s1_kind_r)
      eiec_pkg::KIND_TICK: begin
        pend_nxt = pend_r | (((levels & ~prev_r & rise_en_r)
                            | (~levels & prev_r & fall_en_r)) & LINE_MASK);
        prev_nxt = levels;
      end
      eiec_pkg::KIND_WRITE: begin
        case (s1_reg_r)
          eiec_pkg::REG_MASK: mask_nxt = wdata_m;
          eiec_pkg::REG_SWT: begin
            // only newly raised trigger bits on unmasked lines set pending
            pend_nxt = pend_r | (wdata_m & ~soft_r & mask_r);
            soft_nxt = soft_r | wdata_m;
          end
          eiec_pkg::REG_PEND: begin
            pend_nxt = pend_r & ~wdata_m;
            soft_nxt = soft_r & ~wdata_m;
          end
          default: ;
        endcase
      end
      eiec_pkg::KIND_READ: begin
        case (s1_reg_r)
          eiec_pkg::REG_MASK: rdata = mask_r;
          eiec_pkg::REG_SWT:  rdata = soft_r;
          eiec_pkg::REG_PEND: rdata = pend_r;
          default:            rdata = '0;
        endcase
      end
      default: ;
    endcase
    irq = pend_nxt & mask_nxt & LINE_MASK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      mask_r <= '0;
      pend_r <= '0;
      soft_r <= '0;
    end else if (s1_fire) begin
      prev_r <= prev_nxt;
      mask_r <= mask_nxt;
      pend_r <= pend_nxt;
      soft_r <= soft_nxt;
    end
  end

  // result register
  logic                             out_valid_r;
  logic [eiec_pkg::OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data_r <= {(eiec_pkg::OUT_TDATA_W - 2*LW - 1)'(0), |irq, irq, rdata};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`include "external_interrupt_edge_controller_unit_assert.svh"

  `EIEC_ASSERT_IMP(a_irq_any_match, out_tvalid,
                   out_tdata[2*LW] == (out_tdata[2*LW-1:LW] != '0))
  `EIEC_ASSERT_IMP(a_state_in_lines, 1'b1,
                   ((pend_r | mask_r | soft_r | prev_r) & ~LINE_MASK) == '0)
  `EIEC_ASSERT_NXT(a_pend_clear,
                   s1_fire && s1_kind_r == eiec_pkg::KIND_WRITE
                   && s1_reg_r == eiec_pkg::REG_PEND,
                   ((pend_r | soft_r) & $past(wdata_m)) == '0)
  `EIEC_ASSERT_NXT(a_prev_hold,
                   !(s1_fire && s1_kind_r == eiec_pkg::KIND_TICK),
                   $stable(prev_r))

endmodule

`default_nettype wire

// File: tb/exti_irq_checker.sv
// ----------------------------------------------------------------------------
// exti_irq_checker
// watches the item and result streams of the external interrupt controller,
// keeps its own copy of line state and configuration, and compares every
// result against the interrupt request and read data it works out
// ----------------------------------------------------------------------------
module exti_irq_checker
  import eiec_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // wdata, pin_levels
  input  logic [IN_TUSER_W-1:0]  in_tuser,   // kind, reg_sel
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // rdata, irq_lines, irq_any
  input  logic                   cfg_we,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     mismatch_count,
  output int                     results_due
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [LINE_W-1:0] rdata;
    logic [LINE_W-1:0] irq_lines;
    logic              irq_any;
  } irq_result_t;

  logic [SELS_W-1:0] port_sel_q;
  logic [LINE_W-1:0] rise_en_q;
  logic [LINE_W-1:0] fall_en_q;
  logic [LINE_W-1:0] last_levels;
  logic [LINE_W-1:0] mask_q;
  logic [LINE_W-1:0] pend_q;
  logic [LINE_W-1:0] swt_q;
  irq_result_t       irq_due_q[$];
  int                fails = 0;

  // selects past the configured or carried ports read as low
  function automatic logic [LINE_W-1:0] line_levels(input logic [PINS_W-1:0] pins);
    logic [LINE_W-1:0] lv;
    int unsigned       port;
    lv = '0;
    for (int l = 0; l < LINE_W; l++) begin
      port = 32'(port_sel_q[l*SEL_W +: SEL_W]);
      if (port < NUM_PORTS_DEF && port < CARRIED_PORTS) lv[l] = pins[port*PORT_W + l];
    end
    return lv;
  endfunction

  function automatic irq_result_t exti_step(input logic [KIND_W-1:0]   kind,
                                            input logic [REGSEL_W-1:0] regsel,
                                            input logic [LINE_W-1:0]   wdata,
                                            input logic [PINS_W-1:0]   pins);
    irq_result_t       r;
    logic [LINE_W-1:0] now;
    r = '0;
    case (kind)
      KIND_TICK: begin
        now = line_levels(pins);
        pend_q |= (now & ~last_levels & rise_en_q) | (~now & last_levels & fall_en_q);
        last_levels = now;
      end
      KIND_WRITE: begin
        case (regsel)
          REG_MASK: mask_q = wdata;
          REG_SWT: begin
            // only newly raised trigger bits on unmasked lines can set pending
            pend_q |= wdata & ~swt_q & mask_q;
            swt_q  |= wdata;
          end
          REG_PEND: begin
            pend_q &= ~wdata;
            swt_q  &= ~wdata;
          end
          default: ;
        endcase
      end
      KIND_READ: begin
        case (regsel)
          REG_MASK: r.rdata = mask_q;
          REG_SWT:  r.rdata = swt_q;
          REG_PEND: r.rdata = pend_q;
          default:  r.rdata = '0;
        endcase
      end
      default: ;
    endcase
    r.irq_lines = pend_q & mask_q;
    r.irq_any   = |r.irq_lines;
    return r;
  endfunction

  always @(posedge clk) begin
    irq_result_t want;
    irq_result_t got;
    if (!rst_n) begin
      port_sel_q  = '0;
      rise_en_q   = '0;
      fall_en_q   = '0;
      last_levels = '0;
      mask_q      = '0;
      pend_q      = '0;
      swt_q       = '0;
      irq_due_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_PORT_SEL: port_sel_q = cfg_wdata[SELS_W-1:0];
          CFG_RISE_EN:  rise_en_q  = cfg_wdata[LINE_W-1:0];
          CFG_FALL_EN:  fall_en_q  = cfg_wdata[LINE_W-1:0];
          default: ;
        endcase
      end
      // pop before push: a result leaving now is always older than an item entering
      if (out_tvalid && out_tready) begin
        got.rdata     = out_tdata[LINE_W-1:0];
        got.irq_lines = out_tdata[LINE_W +: LINE_W];
        got.irq_any   = out_tdata[2*LINE_W];
        if (irq_due_q.size() == 0) begin
          $error("result transaction with nothing expected: rdata %h irq_lines %h irq_any %b",
                 got.rdata, got.irq_lines, got.irq_any);
          fails++;
        end else begin
          want = irq_due_q.pop_front();
          if (got.rdata !== want.rdata) begin
            $error("rdata mismatch: expected %h actual %h", want.rdata, got.rdata);
            fails++;
          end
          if (got.irq_lines !== want.irq_lines) begin
            $error("irq_lines mismatch: expected %h actual %h", want.irq_lines, got.irq_lines);
            fails++;
          end
          if (got.irq_any !== want.irq_any) begin
            $error("irq_any mismatch: expected %b actual %b", want.irq_any, got.irq_any);
            fails++;
          end
        end
      end
      if (in_tvalid && in_tready)
        irq_due_q.push_back(exti_step(in_tuser[KIND_W-1:0], in_tuser[KIND_W +: REGSEL_W],
                                      in_tdata[LINE_W-1:0], in_tdata[LINE_W +: PINS_W]));
    end
    results_due    <= irq_due_q.size();
    mismatch_count <= fails;
  end

endmodule

// File: tb/tb_external_interrupt_edge_controller_unit.sv
// ----------------------------------------------------------------------------
// tb_external_interrupt_edge_controller_unit
// drives tick, register write, register read and idle-kind transactions into the
// interrupt controller under changing line configurations and random
// backpressure; results are checked by exti_irq_checker
// ----------------------------------------------------------------------------
module tb_external_interrupt_edge_controller_unit;
  import eiec_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [KIND_W-1:0]     KIND_IDLE = 2'd3;
  localparam logic [REGSEL_W-1:0]   REG_SPARE = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SPARE = 2'd3;

  localparam int RANDOM_PHASES   = 6;
  localparam int ITEMS_PER_PHASE = 225;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 8;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr   = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;

  int                mismatch_count;
  int                results_due;
  int                tx_idle_pct = 10;
  int                rx_idle_pct = 66;
  bit                rx_hold     = 1'b0;
  logic [PINS_W-1:0] pin_state   = '0;

  always #5 clk = ~clk;

  external_interrupt_edge_controller_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  exti_irq_checker u_irq_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // result side backpressure, with a single long hold-off
  initial begin
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_tready <= 1'b0;
        for (int c = 1; c < HOLD_CYCLES; c++) @(posedge clk);
        rx_hold = 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("external_interrupt_edge_controller_unit verification failed");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [LINE_W-1:0] rand_wdata();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return 16'h1 << $urandom_range(LINE_W - 1);
      default: return LINE_W'($urandom);
    endcase
  endfunction

  // small changes half the time so edges stay sparse, otherwise jumps or repeats
  function automatic logic [PINS_W-1:0] next_pins(input logic [PINS_W-1:0] cur);
    logic [PINS_W-1:0] p;
    p = cur;
    case ($urandom_range(9))
      0:       p = '0;
      1:       p = '1;
      2, 3:    p = rand64();
      4:       p = cur;
      default: begin
        for (int k = $urandom_range(3); k >= 0; k--) p[$urandom_range(PINS_W - 1)] ^= 1'b1;
      end
    endcase
    return p;
  endfunction

  function automatic logic [SELS_W-1:0] sel_below(input int unsigned top);
    logic [SELS_W-1:0] s;
    for (int l = 0; l < LINE_W; l++) s[l*SEL_W +: SEL_W] = SEL_W'($urandom_range(top));
    return s;
  endfunction

  // expects to be called at a clock edge; returns at the edge of acceptance
  task automatic send_item(input logic [KIND_W-1:0]   kind,
                           input logic [REGSEL_W-1:0] regsel,
                           input logic [LINE_W-1:0]   wdata,
                           input logic [PINS_W-1:0]   pins);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= {regsel, kind};
    in_tdata  <= {pins, wdata};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic program_lines(input logic [SELS_W-1:0] sel, input logic [LINE_W-1:0] rise,
                               input logic [LINE_W-1:0] fall, input bit poke_spare);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_PORT_SEL;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_addr  <= CFG_RISE_EN;
    cfg_wdata <= {(CFG_DATA_W - LINE_W)'(rand64()), rise};
    @(posedge clk);
    cfg_addr  <= CFG_FALL_EN;
    cfg_wdata <= {(CFG_DATA_W - LINE_W)'(rand64()), fall};
    @(posedge clk);
    if (poke_spare) begin
      cfg_addr  <= CFG_SPARE;
      cfg_wdata <= rand64();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    int                  pick;
    int                  r;
    logic [REGSEL_W-1:0] regsel;
    pick = $urandom_range(99);
    if (pick < 50) begin
      pin_state = next_pins(pin_state);
      send_item(KIND_TICK, REGSEL_W'($urandom_range(3)), rand_wdata(), pin_state);
    end else if (pick < 78) begin
      r = $urandom_range(19);
      if (r < 4)       regsel = REG_MASK;
      else if (r < 11) regsel = REG_SWT;
      else if (r < 18) regsel = REG_PEND;
      else             regsel = REG_SPARE;
      send_item(KIND_WRITE, regsel, rand_wdata(), rand64());
    end else if (pick < 95) begin
      send_item(KIND_READ, REGSEL_W'($urandom_range(3)), rand_wdata(), rand64());
    end else begin
      send_item(KIND_IDLE, REGSEL_W'($urandom_range(3)), rand_wdata(), rand64());
    end
  endtask

  initial begin
    logic [SELS_W-1:0] sel;
    logic [LINE_W-1:0] rise;
    logic [LINE_W-1:0] fall;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // lines 8..11 pick ports 4, 5, F and 8, which all read low
    program_lines(64'h3210_8F54_0123_3210, 16'hFFFF, 16'hFFFF, 1'b1);
    send_item(KIND_READ,  REG_MASK,  16'h0000, '0);
    send_item(KIND_READ,  REG_SWT,   16'h0000, '0);
    send_item(KIND_READ,  REG_PEND,  16'h0000, '0);
    send_item(KIND_READ,  REG_SPARE, 16'hFFFF, '1);
    send_item(KIND_WRITE, REG_MASK,  16'hFFFF, '0);
    send_item(KIND_TICK,  REG_MASK,  16'h0000, '1);
    send_item(KIND_READ,  REG_PEND,  16'h0000, '0);
    send_item(KIND_TICK,  REG_MASK,  16'hFFFF, '0);
    send_item(KIND_WRITE, REG_PEND,  16'hFFFF, '0);
    send_item(KIND_WRITE, REG_SWT,   16'h00FF, '0);
    send_item(KIND_WRITE, REG_SWT,   16'h00FF, '0);
    send_item(KIND_READ,  REG_SWT,   16'h0000, '0);
    send_item(KIND_WRITE, REG_MASK,  16'h0F0F, '0);
    send_item(KIND_WRITE, REG_SWT,   16'hFF00, '0);
    send_item(KIND_READ,  REG_PEND,  16'h0000, '0);
    send_item(KIND_WRITE, REG_PEND,  16'hFFFF, '0);
    send_item(KIND_WRITE, REG_SPARE, 16'hFFFF, '1);
    send_item(KIND_IDLE,  REG_MASK,  16'hFFFF, '1);
    send_item(KIND_TICK,  REG_MASK,  16'h0000, '1);
    send_item(KIND_TICK,  REG_SWT,   16'h0000, 64'hAAAA_5555_AAAA_5555);
    send_item(KIND_TICK,  REG_SWT,   16'h0000, 64'hAAAA_5555_AAAA_5555);
    send_item(KIND_WRITE, REG_MASK,  16'h0000, '0);
    send_item(KIND_READ,  REG_MASK,  16'h0000, '0);
    send_item(KIND_TICK,  REG_PEND,  16'h0000, '0);
    send_item(KIND_READ,  REG_PEND,  16'h0000, '0);
    send_item(KIND_WRITE, REG_PEND,  16'h0000, '0);
    pin_state = '0;
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: begin sel = sel_below(3); rise = '1;        fall = '0;        end
        1: begin
          sel  = rand64();
          rise = LINE_W'($urandom);
          fall = LINE_W'($urandom);
        end
        2: begin sel = '1;           rise = '1;        fall = '1;        end
        3: begin sel = '0;           rise = '0;        fall = '1;        end
        4: begin
          sel  = sel_below(7);
          rise = LINE_W'($urandom);
          fall = LINE_W'($urandom);
        end
        default: begin sel = rand64(); rise = '1; fall = '1; end
      endcase
      if (ph < 2) begin
        tx_idle_pct = 10;
        rx_idle_pct = 66;
      end else if (ph < 4) begin
        tx_idle_pct = 66;
        rx_idle_pct = 10;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      program_lines(sel, rise, fall, 1'b0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        // the sender keeps offering while the result side is held off
        if (ph == 0 && i == 40) rx_hold = 1'b1;
        random_item();
      end
      drain();
    end

    if (mismatch_count == 0) begin
      $display("external_interrupt_edge_controller_unit verification clean");
    end else begin
      $display("external_interrupt_edge_controller_unit verification failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/eiec_pkg.sv
rtl/external_interrupt_edge_controller_unit.sv
tb/exti_irq_checker.sv
tb/tb_external_interrupt_edge_controller_unit.sv
